### rtl/core/bed_pkg.sv
// Package for the escape decoder: mode type, character codes, queue parameters, result entry type, hex helper.
package bed_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_OCT  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [7:0] CC_BEL   = 8'd7;
  localparam logic [7:0] CC_BS    = 8'd8;
  localparam logic [7:0] CC_ESC   = 8'd27;
  localparam logic [7:0] CC_LF    = 8'd10;
  localparam logic [7:0] CC_CR    = 8'd13;
  localparam logic [7:0] CC_TAB   = 8'd9;

  // output queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } res_t;

  // {valid, value} of a hex digit character
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
      r = {1'b1, 4'(b[2:0] + 3'd1) + 4'd8};
    end
    return r;
  endfunction

endpackage

### rtl/core/backslash_escape_decoder.sv
// Top level of the backslash escape decoder: input register, decode logic, output queue.
//
//  channel  | ports                                        | dir
//  ---------+----------------------------------------------+-----
//  input    | in_valid, in_stall, in_byte, in_last          | in
//  result   | out_valid, out_stall, out_byte,               | out
//           | out_run_last, out_string_end                  |
//
// A raw byte is taken into an input register; the decode logic and the escape
// state update run on the registered byte once the queue has room, and write
// zero, one or two results into a four-entry output queue. One byte per cycle is
// taken while the queue has room for two results; the output port moves one
// result per cycle while out_stall is low, so bytes that yield two results (a
// numeric escape ended by a plain byte) set the sustained rate.
// Reset (rst_n low, synchronous) returns to text mode and empties the queue.
// in_stall depends only on registered state, never on out_stall in the same cycle.
module backslash_escape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);
  import bed_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // escape state
  mode_t      mode_r, mode_nxt;
  logic [8:0] accum_r, accum_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // output queue
  res_t       q_mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r, count_nxt;

  // decode results
  logic       flush_en;   // escape / numeric value, always first
  logic [7:0] flush_val;
  logic       text_en;    // plain byte emitted after it
  logic [7:0] text_val;
  logic [1:0] push_n;
  res_t       e0, e1;
  logic       adv;
  logic       pop;
  logic [4:0] hv;
  logic       is_oct;
  logic [8:0] acc_oct, acc_hex;
  logic [1:0] cnt_inc;

  // advance needs room for the worst case of two results
  assign adv      = in_valid_r && (count_r <= QCW'(QDEPTH - 2));
  assign in_stall = in_valid_r && !adv;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_byte       = q_mem_r[rd_ptr_r].data;
  assign out_run_last   = q_mem_r[rd_ptr_r].run_last;
  assign out_string_end = q_mem_r[rd_ptr_r].string_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  // decode of one byte against the current escape state
  always_comb begin
    hv      = hex_digit(in_byte_r);
    is_oct  = (in_byte_r >= CH_0) && (in_byte_r <= CH_7);
    acc_oct = {accum_r[5:0], 3'b000} + {6'd0, in_byte_r[2:0]};
    acc_hex = {accum_r[4:0], 4'b0000} + {5'd0, hv[3:0]};
    cnt_inc = cnt_r + 2'd1;

    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    flush_en  = 1'b0;
    flush_val = accum_r[7:0];
    text_en   = 1'b0;
    text_val  = in_byte_r;

    case (mode_r)
      MODE_TEXT: begin
        if (in_byte_r == CH_BSL && !in_last_r) mode_nxt = MODE_ESC;
        else text_en = 1'b1;
      end
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        flush_en = 1'b1;
        case (in_byte_r)
          CH_LA: flush_val = CC_BEL;
          CH_LB: flush_val = CC_BS;
          CH_LE: flush_val = CC_ESC;
          CH_LN: flush_val = CC_LF;
          CH_LR: flush_val = CC_CR;
          CH_LT: flush_val = CC_TAB;
          CH_LX: begin
            accum_nxt = '0;
            cnt_nxt   = 2'd0;
            mode_nxt  = MODE_HEX;
            flush_en  = in_last_r;
            flush_val = 8'd0;
          end
          default: begin
            if (is_oct) begin
              accum_nxt = {6'd0, in_byte_r[2:0]};
              cnt_nxt   = 2'd1;
              mode_nxt  = MODE_OCT;
              flush_en  = in_last_r;
              flush_val = {5'd0, in_byte_r[2:0]};
            end else begin
              flush_val = in_byte_r;
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (is_oct) begin
          accum_nxt = acc_oct;
          cnt_nxt   = cnt_inc;
          flush_val = acc_oct[7:0];
          if (cnt_inc >= 2'd3) begin
            flush_en = 1'b1;
            mode_nxt = MODE_TEXT;
          end else begin
            flush_en = in_last_r;
          end
        end else begin
          flush_en = 1'b1;
          mode_nxt = MODE_TEXT;
          if (in_byte_r == CH_BSL && !in_last_r) mode_nxt = MODE_ESC;
          else text_en = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hv[4]) begin
          accum_nxt = acc_hex;
          cnt_nxt   = cnt_inc;
          flush_val = acc_hex[7:0];
          if (cnt_inc >= 2'd2) begin
            flush_en = 1'b1;
            mode_nxt = MODE_TEXT;
          end else begin
            flush_en = in_last_r;
          end
        end else begin
          flush_en = 1'b1;
          mode_nxt = MODE_TEXT;
          if (in_byte_r == CH_BSL && !in_last_r) mode_nxt = MODE_ESC;
          else text_en = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_TEXT;
      end
    endcase

    // leaving numeric mode or end of string clears the pending value
    if (mode_nxt == MODE_TEXT || in_last_r) begin
      mode_nxt  = MODE_TEXT;
      accum_nxt = '0;
      cnt_nxt   = 2'd0;
    end

    push_n = {1'b0, flush_en} + {1'b0, text_en};

    // flags go to the final result of this byte
    e0.data       = flush_en ? flush_val : text_val;
    e0.run_last   = (push_n == 2'd1);
    e0.string_end = (push_n == 2'd1) && in_last_r;
    e1.data       = text_val;
    e1.run_last   = 1'b1;
    e1.string_end = in_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      accum_r <= '0;
      cnt_r   <= 2'd0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // queue write: up to two entries per advanced byte
  always_ff @(posedge clk) begin
    if (adv && push_n != 2'd0) begin
      q_mem_r[wr_ptr_r] <= e0;
      if (push_n == 2'd2) q_mem_r[wr_ptr_r + QAW'(1)] <= e1;
    end
  end

  always_comb begin
    count_nxt = count_r + (adv ? QCW'(push_n) : QCW'(0)) - (pop ? QCW'(1) : QCW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (adv) wr_ptr_r <= wr_ptr_r + QAW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + QAW'(1);
      count_r <= count_nxt;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("output queue overfilled");

  a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |-> (push_n != 2'd0))
    else $error("string end produced no result");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (mode_r == MODE_TEXT && accum_r == '0 && cnt_r == 2'd0))
    else $error("state not cleared after string end");

  a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_TEXT) |-> (accum_r == '0 && cnt_r == 2'd0))
    else $error("stale escape value in text mode");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> (count_r + QCW'(push_n) <= QCW'(QDEPTH)))
    else $error("queue write without room");

endmodule
